>>> hw/rtl/avst_pkg.sv
package avst_pkg;

  localparam int REG_W       = 16;
  localparam int OUT_W       = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int ROUND_SHIFT = 7;
  localparam int ROUND_ADD   = 64;

  localparam logic [REG_W-1:0] GAIN_RESET    = 16'd256;
  localparam logic [REG_W-1:0] BIAS_RESET    = 16'd0;
  localparam logic [REG_W-1:0] READOUT_RESET = 16'd0;
  localparam logic [REG_W-1:0] SCALE_RESET   = 16'd128;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAIN    = 3'd0,
    CFG_BIAS    = 3'd1,
    CFG_READOUT = 3'd2,
    CFG_SCALE   = 3'd3
  } cfg_reg_t;

  // flags that ride alongside a pixel through the pipeline
  typedef struct packed {
    logic last;
    logic clamped;
  } side_t;

endpackage

>>> hw/rtl/avst_sqrt_pipe.sv
module avst_sqrt_pipe #(
  parameter int ROOT_W = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   in_rad,
  input  avst_pkg::side_t       in_side,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     out_root,
  output avst_pkg::side_t       out_side
);

  localparam int SQ_W  = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  // index k holds the input of stage k; stage k registers into k+1
  logic                  valid_q [0:ROOT_W];
  logic [ROOT_W-1:0]     root_q  [0:ROOT_W];
  avst_pkg::side_t       side_q  [0:ROOT_W];
  logic [REM_W-1:0]      rem_q   [0:ROOT_W-1];
  logic [SQ_W-1:0]       x_q     [0:ROOT_W-1];

  assign valid_q[0] = in_valid;
  assign root_q[0]  = '0;
  assign side_q[0]  = in_side;
  assign rem_q[0]   = '0;
  assign x_q[0]     = in_rad;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    // top bits of rem are always zero here, so dropping them is safe
    assign rem_sh = {rem_q[k][ROOT_W-1:0], x_q[k][SQ_W-1 -: 2]};
    assign trial  = {root_q[k], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k+1] <= 1'b0;
      end else begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk) begin
      root_q[k+1] <= {root_q[k][ROOT_W-2:0], take};
      side_q[k+1] <= side_q[k];
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[k+1] <= take ? (rem_sh - trial) : rem_sh;
        x_q[k+1]   <= {x_q[k][SQ_W-3:0], 2'b00};
      end
    end
  end

  assign out_valid = valid_q[ROOT_W];
  assign out_root  = root_q[ROOT_W];
  assign out_side  = side_q[ROOT_W];

endmodule

>>> hw/rtl/anscombe_variance_stabiliser_core.sv
// Generalised Anscombe transform, one pixel per request.
//   out = scale * sqrt(gain*(pixel - bias) + readout^2 + 0.375*gain^2)
// Input: a request is taken on a rising edge with start high and busy low.
//   busy stays low, so a pixel can be issued on every cycle.
// Config: cfg_valid/cfg_ready write port, cfg_index selects gain (0), bias (1),
//   readout noise (2) or output scale (3); other indexes are ignored. Only
//   write while no pixel is in flight. cfg_ready is always high.
// Output: result_valid strobes for one cycle with stabilised_value (Q20.12,
//   saturating), radicand_clamped and last_out. There is no back-pressure;
//   the receiver must take every result as it appears.
// Stages: products, radicand sum, one square-root bit per stage, scale
//   multiply, round/saturate.
// Throughput: one pixel per cycle, fixed by the fully pipelined root.
// Reset: rst (synchronous) empties the pipeline and loads gain = 1.0,
//   bias = 0, readout noise = 0, scale = 0.5.
module anscombe_variance_stabiliser_core #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [PIXEL_BITS-1:0]               pixel_value,
  input  logic                                last_in,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [avst_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [avst_pkg::REG_W-1:0]          cfg_data,
  output logic                                result_valid,
  output logic [avst_pkg::OUT_W-1:0]          stabilised_value,
  output logic                                radicand_clamped,
  output logic                                last_out
);

  localparam int REG_W   = avst_pkg::REG_W;
  localparam int OUT_W   = avst_pkg::OUT_W;
  localparam int DIFF_W  = ((PIXEL_BITS > REG_W) ? PIXEL_BITS : REG_W) + 1;
  localparam int GD_W    = DIFF_W + REG_W + 1;
  localparam int RAD_W   = GD_W + 12;
  localparam int X_W     = RAD_W + 2;
  localparam int ROOT_W  = (X_W + 1) / 2;
  localparam int SQ_W    = 2 * ROOT_W;
  localparam int PROD_W  = ROOT_W + REG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SH_W    = SUM_W - avst_pkg::ROUND_SHIFT;
  localparam int LATENCY = ROOT_W + 4;

  logic [REG_W-1:0] gain_q8;
  logic [REG_W-1:0] bias_level;
  logic [REG_W-1:0] readout_noise_q8;
  logic [REG_W-1:0] output_scale_q8;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q8          <= avst_pkg::GAIN_RESET;
      bias_level       <= avst_pkg::BIAS_RESET;
      readout_noise_q8 <= avst_pkg::READOUT_RESET;
      output_scale_q8  <= avst_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        avst_pkg::CFG_GAIN:    gain_q8          <= cfg_data;
        avst_pkg::CFG_BIAS:    bias_level       <= cfg_data;
        avst_pkg::CFG_READOUT: readout_noise_q8 <= cfg_data;
        avst_pkg::CFG_SCALE:   output_scale_q8  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: the three products
  logic                     v1;
  logic signed [GD_W-1:0]   gd_q;
  logic [2*REG_W-1:0]       rr_q;
  logic [2*REG_W-1:0]       gg_q;
  logic                     last1;
  logic signed [DIFF_W-1:0] diff_s;

  assign diff_s = $signed(DIFF_W'(pixel_value)) - $signed(DIFF_W'(bias_level));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    gd_q  <= $signed({1'b0, gain_q8}) * diff_s;
    rr_q  <= readout_noise_q8 * readout_noise_q8;
    gg_q  <= gain_q8 * gain_q8;
    last1 <= last_in;
  end

  // stage 2: radicand, Q.19, then clamp and scale by 8 for the root
  logic                    v2;
  logic [SQ_W-1:0]         x2;
  avst_pkg::side_t         side2;
  logic signed [RAD_W-1:0] rad_s;

  always_comb begin
    rad_s = (RAD_W'(gd_q) <<< 11)
          + $signed(RAD_W'({rr_q, 3'b000}))
          + $signed(RAD_W'(gg_q))
          + $signed(RAD_W'({gg_q, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    side2.last    <= last1;
    side2.clamped <= rad_s[RAD_W-1];
    if (rad_s[RAD_W-1]) begin
      x2 <= '0;
    end else begin
      x2 <= SQ_W'({rad_s[RAD_W-2:0], 3'b000});
    end
  end

  logic              vr;
  logic [ROOT_W-1:0] root;
  avst_pkg::side_t   sider;

  avst_sqrt_pipe #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_rad    (x2),
    .in_side   (side2),
    .out_valid (vr),
    .out_root  (root),
    .out_side  (sider)
  );

  // scale multiply
  logic              vm;
  logic [PROD_W-1:0] prod_q;
  avst_pkg::side_t   sidem;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else begin
      vm <= vr;
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= root * output_scale_q8;
    sidem  <= sider;
  end

  // round to Q.12 and saturate
  logic [SUM_W-1:0] rounded;
  logic [SH_W-1:0]  shifted;

  assign rounded = SUM_W'(prod_q) + SUM_W'(avst_pkg::ROUND_ADD);
  assign shifted = rounded[SUM_W-1:avst_pkg::ROUND_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (|shifted[SH_W-1:OUT_W]) begin
      stabilised_value <= '1;
    end else begin
      stabilised_value <= shifted[OUT_W-1:0];
    end
    radicand_clamped <= sidem.clamped;
    last_out         <= sidem.last;
  end

endmodule

>>> hw/rtl/avst_checker.sv
module avst_checker #(
  parameter int LAT        = 28,
  parameter int PIXEL_BITS = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             last_in,
  input logic                             result_valid,
  input logic [avst_pkg::OUT_W-1:0]       stabilised_value,
  input logic                             radicand_clamped,
  input logic                             last_out
);

  localparam int AGE_W = $clog2(LAT + 1);

  // cycles since reset, saturating once the pipeline has fully refilled
  logic [AGE_W-1:0] age;

  always_ff @(posedge clk) begin
    if (rst) begin
      age <= '0;
    end else if (age != AGE_W'(LAT)) begin
      age <= age + 1'b1;
    end
  end

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result strobe straight after reset");

  a_clamp_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && radicand_clamped |-> stabilised_value == '0)
    else $error("clamped radicand with non-zero result");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    age == AGE_W'(LAT) |-> result_valid == $past(start && !busy, LAT))
    else $error("result strobe does not match request latency");

  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    age == AGE_W'(LAT) && result_valid |-> last_out == $past(last_in, LAT))
    else $error("last flag lost in pipeline");

endmodule

bind anscombe_variance_stabiliser_core avst_checker #(
  .LAT        (LATENCY),
  .PIXEL_BITS (PIXEL_BITS)
) u_avst_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .last_in          (last_in),
  .result_valid     (result_valid),
  .stabilised_value (stabilised_value),
  .radicand_clamped (radicand_clamped),
  .last_out         (last_out)
);

>>> tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_W       = avst_pkg::REG_W;
  localparam int OUT_W       = avst_pkg::OUT_W;
  localparam int CFG_INDEX_W = avst_pkg::CFG_INDEX_W;

  localparam int LATENCY     = 28;
  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 46;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST_UNUSED  = 3'd7;
  localparam logic [OUT_W-1:0] SAT_VALUE = {OUT_W{1'b1}};

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             clamped;
    logic             last;
  } pixel_result_t;

  class stabiliser_scoreboard;
    logic [REG_W-1:0] gain, bias, readout, scale;
    pixel_result_t    pending_results[$];
    int errors, n_pixels, n_checked, n_clamped, n_saturated;

    function new();
      gain    = avst_pkg::GAIN_RESET;
      bias    = avst_pkg::BIAS_RESET;
      readout = avst_pkg::READOUT_RESET;
      scale   = avst_pkg::SCALE_RESET;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [REG_W-1:0] data);
      case (idx)
        avst_pkg::CFG_GAIN:    gain = data;
        avst_pkg::CFG_BIAS:    bias = data;
        avst_pkg::CFG_READOUT: readout = data;
        avst_pkg::CFG_SCALE:   scale = data;
        default: ;
      endcase
    endfunction

    // floor square root, one result bit at a time from the top
    function longint unsigned int_root(longint unsigned x);
      longint unsigned r, t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= x) r = t;
      end
      return r;
    endfunction

    function pixel_result_t stabilise(logic [15:0] pix, logic last);
      pixel_result_t    res;
      longint           diff, rad;
      longint unsigned  radu, root, prod, rounded;
      diff = longint'(pix) - longint'(bias);
      // radicand with 19 fraction bits
      rad = longint'(gain) * diff * 2048
          + longint'(readout) * longint'(readout) * 8
          + 3 * longint'(gain) * longint'(gain);
      res.clamped = (rad < 0);
      radu = res.clamped ? 64'd0 : longint'(rad);
      root = int_root(radu * 8);
      prod = root * longint'(scale);
      rounded = (prod + avst_pkg::ROUND_ADD) >> avst_pkg::ROUND_SHIFT;
      res.value = (rounded > longint'(SAT_VALUE)) ? SAT_VALUE : rounded[OUT_W-1:0];
      res.last = last;
      return res;
    endfunction

    function void note_pixel(logic [15:0] pix, logic last);
      pending_results.push_back(stabilise(pix, last));
      n_pixels++;
    endfunction

    function void check_result(logic [OUT_W-1:0] value, logic clamped, logic last);
      pixel_result_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value %h clamped %b last %b",
                 $time, value, clamped, last);
        return;
      end
      exp_r = pending_results.pop_front();
      n_checked++;
      if (exp_r.clamped) n_clamped++;
      if (exp_r.value == SAT_VALUE) n_saturated++;
      if (value !== exp_r.value) begin
        errors++;
        $display("%0t: stabilised_value expected %h actual %h", $time, exp_r.value, value);
      end
      if (clamped !== exp_r.clamped) begin
        errors++;
        $display("%0t: radicand_clamped expected %b actual %b", $time, exp_r.clamped, clamped);
      end
      if (last !== exp_r.last) begin
        errors++;
        $display("%0t: last_out expected %b actual %b", $time, exp_r.last, last);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [15:0]            pixel_value;
  logic                   last_in;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [REG_W-1:0]       cfg_data;
  logic                   result_valid;
  logic [OUT_W-1:0]       stabilised_value;
  logic                   radicand_clamped;
  logic                   last_out;

  stabiliser_scoreboard sb;
  int quiet_cycles;
  int n_settings;

  anscombe_variance_stabiliser_core #(.PIXEL_BITS(16)) u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .pixel_value      (pixel_value),
    .last_in          (last_in),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .result_valid     (result_valid),
    .stabilised_value (stabilised_value),
    .radicand_clamped (radicand_clamped),
    .last_out         (last_out)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(stabilised_value, radicand_clamped, last_out);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // all driving tasks start and end just after a falling edge
  task automatic send_pixel(logic [15:0] pix, logic last);
    start = 1'b1;
    pixel_value = pix;
    last_in = last;
    do @(posedge clk); while (busy);
    sb.note_pixel(pix, last);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [REG_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // every pixel yields a result, so an empty store means nothing in flight
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_all(logic [REG_W-1:0] g, logic [REG_W-1:0] b,
                           logic [REG_W-1:0] r, logic [REG_W-1:0] s);
    drain();
    write_reg(avst_pkg::CFG_GAIN, g);
    write_reg(avst_pkg::CFG_BIAS, b);
    write_reg(avst_pkg::CFG_READOUT, r);
    write_reg(avst_pkg::CFG_SCALE, s);
    // unmapped index must leave the registers alone
    write_reg(CFG_INDEX_W'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED)),
              REG_W'($urandom));
    n_settings++;
  endtask

  function automatic logic [REG_W-1:0] pick_reg();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return REG_W'($urandom_range(0, 1023));
      3:       return REG_W'($urandom_range(128, 1024));
      default: return REG_W'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_pixel(logic [15:0] b);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return 16'(b + $urandom_range(0, 64) - 16'd32);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int burst, gap, items;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    pixel_value = '0;
    last_in = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    n_settings = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // values straight out of reset
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'hAAAA, 1'b1);
    start = 1'b0;
    // everything at maximum: pixel below bias clamps
    write_all('1, '1, '1, '1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h8000, 1'b1);
    start = 1'b0;
    // saturation
    write_all('1, '0, '1, '1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b1);
    start = 1'b0;
    // zero gain, zero scale
    write_all('0, '0, '0, '0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b1);
    start = 1'b0;
    // just below, at and above the bias
    write_all(16'd256, 16'd1000, 16'd0, 16'd512);
    send_pixel(16'd999, 1'b0);
    send_pixel(16'd1000, 1'b0);
    send_pixel(16'd1001, 1'b1);
    start = 1'b0;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_all(pick_reg(), pick_reg(), pick_reg(), pick_reg());
      items = 0;
      while (items < PHASE_ITEMS) begin
        burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        for (int k = 0; k < burst; k++) begin
          send_pixel(pick_pixel(sb.bias), $urandom_range(0, 7) == 0);
          items++;
        end
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          start = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      start = 1'b0;
    end

    drain();
    repeat (2 * LATENCY) @(posedge clk);
    $display("%0d pixels over %0d register settings, %0d results checked",
             sb.n_pixels, n_settings + 1, sb.n_checked);
    $display("%0d clamped radicands, %0d saturated outputs", sb.n_clamped, sb.n_saturated);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
